### design/atce_pkg.sv
// Shared types, codes and colour tables for the text console engine.
`default_nettype none

package atce_pkg;

    localparam int COL_W  = 9;
    localparam int ROW_W  = 8;
    localparam int RGB_W  = 24;
    localparam int CHAR_W = 8;
    localparam int REG_IDX_W = 2;
    localparam int OUT_DATA_W = 80;

    // Register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_FORE = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_BACK = 2'd3;

    localparam logic [COL_W-1:0] COLUMN_COUNT_RST = 9'd80;
    localparam logic [ROW_W-1:0] ROW_COUNT_RST    = 8'd30;
    localparam logic [RGB_W-1:0] DEFAULT_FORE_RST = 24'haaaaaa;
    localparam logic [RGB_W-1:0] DEFAULT_BACK_RST = 24'h000000;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1b;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5b;
    localparam logic [CHAR_W-1:0] CH_SGR    = 8'h6d;

    // Event kinds
    localparam logic EV_DRAW   = 1'b0;
    localparam logic EV_SCROLL = 1'b1;

    typedef enum logic [1:0] {
        PH_TEXT  = 2'd0,
        PH_ESC   = 2'd1,
        PH_PARAM = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic              kind;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [CHAR_W-1:0] glyph;
        logic [RGB_W-1:0]  fore;
        logic [RGB_W-1:0]  back;
        logic              last;
    } result_t;

    typedef struct packed {
        logic emit;
        logic done;
    } step_t;

    localparam logic [RGB_W-1:0] PAL_NORMAL [8] = '{
        24'h000000, 24'haa0000, 24'h00aa00, 24'haa5500,
        24'h0000aa, 24'haa00aa, 24'h00aaaa, 24'haaaaaa
    };
    localparam logic [RGB_W-1:0] PAL_BRIGHT [8] = '{
        24'h555555, 24'hff5555, 24'h55ff55, 24'hffff55,
        24'h5555ff, 24'hff55ff, 24'h55ffff, 24'hffffff
    };

endpackage

`default_nettype wire

### design/atce_esc.sv
// Escape sequence parser and current SGR colour registers.
`default_nettype none

module atce_esc (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       take,
    input  wire logic [atce_pkg::CHAR_W-1:0] char_code,
    input  wire logic [atce_pkg::RGB_W-1:0]  dflt_fore,
    input  wire logic [atce_pkg::RGB_W-1:0]  dflt_back,
    output logic                            text_mode,
    output logic [atce_pkg::RGB_W-1:0]       fore,
    output logic [atce_pkg::RGB_W-1:0]       back
);
    import atce_pkg::*;

    esc_phase_t        phase_reg, phase_next;
    logic              bad_reg, bad_next;
    logic              second_reg, second_next;
    logic [7:0]        p1_reg, p1_next;
    logic              p1_present_reg, p1_present_next;
    logic [7:0]        p2_reg, p2_next;
    logic [RGB_W-1:0]  fore_reg, fore_next;
    logic [RGB_W-1:0]  back_reg, back_next;

    logic              is_letter;
    logic              is_digit;
    logic [3:0]        digit;
    logic [7:0]        acc;
    logic [11:0]       acc_x10;
    logic [7:0]        acc_sat;

    assign is_letter = (char_code >= 8'h61 && char_code <= 8'h7a) ||
                       (char_code >= 8'h41 && char_code <= 8'h5a);
    assign is_digit  = (char_code >= 8'h30 && char_code <= 8'h39);
    assign digit     = char_code[3:0];
    assign acc       = second_reg ? p2_reg : p1_reg;
    // times ten as two shifts, saturate at 255
    assign acc_x10   = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, digit};
    assign acc_sat   = (acc_x10 > 12'd255) ? 8'hff : acc_x10[7:0];

    always_comb
    begin
        phase_next      = phase_reg;
        bad_next        = bad_reg;
        second_next     = second_reg;
        p1_next         = p1_reg;
        p1_present_next = p1_present_reg;
        p2_next         = p2_reg;
        fore_next       = fore_reg;
        back_next       = back_reg;
        if (take)
        begin
            case (phase_reg)
                PH_TEXT:
                begin
                    if (char_code == CH_ESC)
                        phase_next = PH_ESC;
                end
                PH_ESC:
                begin
                    bad_next        = (char_code != CH_LBRACK);
                    second_next     = 1'b0;
                    p1_next         = 8'd0;
                    p1_present_next = 1'b0;
                    p2_next         = 8'd0;
                    phase_next      = PH_PARAM;
                end
                default:
                begin
                    if (is_letter)
                    begin
                        phase_next = PH_TEXT;
                        if (!bad_reg && char_code == CH_SGR)
                        begin
                            if (!p1_present_reg || p1_reg == 8'd0)
                            begin
                                fore_next = dflt_fore;
                                back_next = dflt_back;
                            end
                            else if (p1_reg == 8'd1)
                            begin
                                if (p2_reg >= 8'd30 && p2_reg <= 8'd37)
                                    fore_next = PAL_BRIGHT[3'(p2_reg - 8'd30)];
                                else if (p2_reg >= 8'd40 && p2_reg <= 8'd47)
                                    back_next = PAL_BRIGHT[3'(p2_reg - 8'd40)];
                            end
                            else if (p1_reg >= 8'd30 && p1_reg <= 8'd37)
                                fore_next = PAL_NORMAL[3'(p1_reg - 8'd30)];
                            else if (p1_reg >= 8'd40 && p1_reg <= 8'd47)
                                back_next = PAL_NORMAL[3'(p1_reg - 8'd40)];
                        end
                    end
                    else if (is_digit)
                    begin
                        if (second_reg)
                            p2_next = acc_sat;
                        else
                        begin
                            p1_next         = acc_sat;
                            p1_present_next = 1'b1;
                        end
                    end
                    else if (char_code == CH_SEMI && !second_reg)
                        second_next = 1'b1;
                    else
                        bad_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TEXT;
            bad_reg        <= 1'b0;
            second_reg     <= 1'b0;
            p1_reg         <= 8'd0;
            p1_present_reg <= 1'b0;
            p2_reg         <= 8'd0;
            fore_reg       <= DEFAULT_FORE_RST;
            back_reg       <= DEFAULT_BACK_RST;
        end
        else
        begin
            phase_reg      <= phase_next;
            bad_reg        <= bad_next;
            second_reg     <= second_next;
            p1_reg         <= p1_next;
            p1_present_reg <= p1_present_next;
            p2_reg         <= p2_next;
            fore_reg       <= fore_next;
            back_reg       <= back_next;
        end
    end

    assign text_mode = (phase_reg == PH_TEXT);
    assign fore      = fore_reg;
    assign back      = back_reg;

    a_esc_enters_param : assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == PH_ESC) |=> (phase_reg == PH_PARAM))
        else $error("escape phase did not move to parameters");
    a_colours_only_on_letter : assert property (@(posedge clk) disable iff (!rst_n)
        (!(take && phase_reg == PH_PARAM && is_letter)) |=>
        ($stable(fore_reg) && $stable(back_reg)))
        else $error("colours changed outside a final letter");
    a_no_bad_to_param : assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == PH_ESC && char_code != CH_LBRACK) |=> bad_reg)
        else $error("sequence without bracket not marked bad");

endmodule

`default_nettype wire

### design/atce_cursor.sv
// Cursor registers and per-cycle result builder for draws, tabs and scrolls.
`default_nettype none

module atce_cursor (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        take,
    input  wire logic [atce_pkg::CHAR_W-1:0]  char_code,
    input  wire logic                        text_mode,
    input  wire logic [atce_pkg::COL_W-1:0]   column_count,
    input  wire logic [atce_pkg::ROW_W-1:0]   row_count,
    input  wire logic [atce_pkg::RGB_W-1:0]   fore,
    input  wire logic [atce_pkg::RGB_W-1:0]   back,
    output atce_pkg::result_t                res,
    output atce_pkg::step_t                  ctl
);
    import atce_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             pend_reg, pend_next;

    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;
    logic [COL_W-1:0] col_inc;
    logic             wrap;
    logic             nl_scroll;

    assign cols      = (column_count == '0) ? COL_W'(1) : column_count;
    assign rows      = (row_count == '0) ? ROW_W'(1) : row_count;
    assign col_inc   = col_reg + COL_W'(1);
    assign wrap      = (col_inc >= cols) || (col_inc == '0);
    assign nl_scroll = !(({1'b0, row_reg} + 9'd1) < {1'b0, rows});

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        pend_next  = pend_reg;
        ctl.emit   = 1'b0;
        ctl.done   = 1'b1;
        res.kind   = EV_DRAW;
        res.column = col_reg;
        res.row    = row_reg;
        res.glyph  = char_code;
        res.fore   = fore;
        res.back   = back;
        res.last   = 1'b1;
        if (pend_reg)
        begin
            // scroll left over from a draw that wrapped on the last row
            ctl.emit   = 1'b1;
            res.kind   = EV_SCROLL;
            res.column = '0;
            res.row    = '0;
            res.glyph  = '0;
            res.fore   = '0;
            col_next   = '0;
            row_next   = rows - ROW_W'(1);
            pend_next  = 1'b0;
        end
        else if (text_mode && char_code != CH_ESC)
        begin
            if (char_code == CH_NL)
            begin
                col_next = '0;
                if (!nl_scroll)
                    row_next = row_reg + ROW_W'(1);
                else
                begin
                    ctl.emit   = 1'b1;
                    res.kind   = EV_SCROLL;
                    res.column = '0;
                    res.row    = '0;
                    res.glyph  = '0;
                    res.fore   = '0;
                    row_next   = rows - ROW_W'(1);
                end
            end
            else if (char_code == CH_BS)
            begin
                if (col_reg != '0)
                    col_next = col_reg - COL_W'(1);
            end
            else
            begin
                ctl.emit = 1'b1;
                if (char_code == CH_TAB)
                    res.glyph = CH_SPACE;
                if (wrap)
                begin
                    col_next = '0;
                    if (!nl_scroll)
                        row_next = row_reg + ROW_W'(1);
                    else
                    begin
                        // keep the byte held so the scroll goes out as a further word
                        pend_next = 1'b1;
                        ctl.done  = 1'b0;
                        res.last  = 1'b0;
                    end
                end
                else
                begin
                    col_next = col_inc;
                    if (char_code == CH_TAB)
                    begin
                        ctl.done = (col_inc[1:0] == 2'b00);
                        res.last = (col_inc[1:0] == 2'b00);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (take)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
        end
    end

    a_pend_gives_scroll : assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (ctl.emit && res.kind == EV_SCROLL && res.last && ctl.done))
        else $error("pending scroll not issued");
    a_last_matches_done : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (res.last == ctl.done))
        else $error("last marker disagrees with completion");
    a_pend_set_by_wrap : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> ($past(take) && $past(wrap) && $past(nl_scroll)))
        else $error("pending scroll without a wrap on the last row");

endmodule

`default_nettype wire

### design/atce_obuf.sv
// Two-word output buffer that decouples the result stream from the receiver.
`default_nettype none

module atce_obuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire atce_pkg::result_t push_word,
    output logic                   space,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output atce_pkg::result_t      out_word
);
    import atce_pkg::*;

    logic    v0_reg, v0_next;
    logic    v1_reg, v1_next;
    result_t d0_reg, d0_next;
    result_t d1_reg, d1_next;
    logic    pop;

    assign pop = v0_reg && out_ready;

    always_comb
    begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        d0_next = d0_reg;
        d1_next = d1_reg;
        if (pop)
        begin
            v0_next = v1_reg;
            d0_next = d1_reg;
            v1_next = 1'b0;
        end
        if (push)
        begin
            if (!v0_next)
            begin
                v0_next = 1'b1;
                d0_next = push_word;
            end
            else
            begin
                v1_next = 1'b1;
                d1_next = push_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

    assign space     = !v1_reg;
    assign out_valid = v0_reg;
    assign out_word  = d0_reg;

    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> !push)
        else $error("word pushed into a full buffer");
    a_skid_implies_head : assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> v0_reg)
        else $error("skid word held without a head word");
    a_head_holds_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (v0_reg && !out_ready) |=> (v0_reg && d0_reg == $past(d0_reg)))
        else $error("head word lost while stalled");

endmodule

`default_nettype wire

### design/ansi_text_console_engine_top.sv
// Top level of the ANSI SGR text console engine.
// Console bytes enter on the s_axis channel (tdata[7:0] = byte). Each byte
// yields zero to five words on m_axis: cell draws (tuser = 0) carrying the
// column, row, glyph and colours, or a scroll-up event (tuser = 1) carrying
// the clear colour. tlast marks the final word caused by one byte.
// A byte is held in an input register; the cursor logic turns it into one
// word per cycle while the output buffer has room. A printable byte that
// wraps on the last row yields a draw and then a scroll. The next byte is
// taken in the cycle its predecessor finishes, giving one byte per cycle
// for plain text while the buffer has room. A word passes the input
// register and the output buffer register before it reaches m_axis.
// Words pass through a two-word output buffer; when the receiver stalls the
// buffer fills and input is held. s_axis_tready does not depend
// combinationally on m_axis_tready.
// Reset clears the cursor, the escape parser and the buffer, and loads the
// colour and geometry registers with their defaults (80 x 30, grey on black).
// Configuration is written through cfg_we / cfg_index / cfg_data while idle.
`default_nettype none

module ansi_text_console_engine_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // [7:0] byte_in
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [8:0] cell_column, [16:9] cell_row, [24:17] glyph_code,
    // [48:25] fore_rgb, [72:49] back_rgb, [79:73] zero
    output logic [atce_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tuser,  // [0] event_kind
    output logic                                   m_axis_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [atce_pkg::REG_IDX_W-1:0]    cfg_index,
    input  wire logic [atce_pkg::RGB_W-1:0]        cfg_data
);
    import atce_pkg::*;

    logic [COL_W-1:0]  column_count_reg;
    logic [ROW_W-1:0]  row_count_reg;
    logic [RGB_W-1:0]  dflt_fore_reg;
    logic [RGB_W-1:0]  dflt_back_reg;

    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_byte_reg;

    logic              text_mode;
    logic [RGB_W-1:0]  fore;
    logic [RGB_W-1:0]  back;
    result_t           res;
    step_t             ctl;
    logic              space;
    logic              fire;
    logic              finish;
    logic              accept;
    result_t           out_word;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= COLUMN_COUNT_RST;
            row_count_reg    <= ROW_COUNT_RST;
            dflt_fore_reg    <= DEFAULT_FORE_RST;
            dflt_back_reg    <= DEFAULT_BACK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLUMN_COUNT: column_count_reg <= cfg_data[COL_W-1:0];
                REG_ROW_COUNT:    row_count_reg    <= cfg_data[ROW_W-1:0];
                REG_DEFAULT_FORE: dflt_fore_reg    <= cfg_data;
                REG_DEFAULT_BACK: dflt_back_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Advance the held byte when its word has room, or when it makes no word
    assign fire          = in_valid_reg && (!ctl.emit || space);
    assign finish        = fire && ctl.done;
    assign s_axis_tready = !in_valid_reg || finish;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (finish)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= s_axis_tdata;
    end

    atce_esc u_esc (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (fire),
        .char_code (in_byte_reg),
        .dflt_fore (dflt_fore_reg),
        .dflt_back (dflt_back_reg),
        .text_mode (text_mode),
        .fore      (fore),
        .back      (back)
    );

    atce_cursor u_cursor (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (fire),
        .char_code    (in_byte_reg),
        .text_mode    (text_mode),
        .column_count (column_count_reg),
        .row_count    (row_count_reg),
        .fore         (fore),
        .back         (back),
        .res          (res),
        .ctl          (ctl)
    );

    atce_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire && ctl.emit),
        .push_word (res),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = {7'd0, out_word.back, out_word.fore, out_word.glyph,
                           out_word.row, out_word.column};
    assign m_axis_tuser = out_word.kind;
    assign m_axis_tlast = out_word.last;

    a_byte_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !finish) |=> (in_valid_reg && in_byte_reg == $past(in_byte_reg)))
        else $error("held byte changed before it finished");
    a_no_push_when_stalled : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && ctl.emit && !space) |-> !fire)
        else $error("byte advanced with no room for its word");
    a_done_frees_input : assert property (@(posedge clk) disable iff (!rst_n)
        (finish && !accept) |=> !in_valid_reg)
        else $error("finished byte still held");

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking bench for the text console engine: directed byte table, then random streams.
`default_nettype none

module tb;

    import atce_pkg::*;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef struct packed {
        logic [7:0] code;
        logic       typed;
        result_t    word;
    } opening_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [RGB_W-1:0]      cfg_data;

    // Console model: geometry, default colours, cursor, parser and current colours
    logic [COL_W-1:0]  width_cells;
    logic [ROW_W-1:0]  height_rows;
    logic [RGB_W-1:0]  reset_fore;
    logic [RGB_W-1:0]  reset_back;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    esc_phase_t        esc_phase;
    logic              seq_bad;
    logic              on_p2;
    logic              p1_seen;
    logic [7:0]        p1;
    logic [7:0]        p2;
    logic [RGB_W-1:0]  cur_fore;
    logic [RGB_W-1:0]  cur_back;

    result_t           burst [0:4];
    int                burst_n;
    result_t           due_events [$];
    int                fault_count;
    int                sent_bytes;
    logic              steady;

    opening_t          opening_rows [0:24];

    ansi_text_console_engine_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    task automatic add_event(input logic kind, input logic [COL_W-1:0] c,
                             input logic [ROW_W-1:0] r, input logic [7:0] g,
                             input logic [RGB_W-1:0] f, input logic [RGB_W-1:0] bk);
        burst[burst_n] = {kind, c, r, g, f, bk, 1'b0};
        burst_n++;
    endtask

    task automatic line_feed();
        int unsigned rows;
        rows = (height_rows == 0) ? 1 : height_rows;
        cur_col = '0;
        if (int'(cur_row) + 1 < rows)
            cur_row = cur_row + 1'b1;
        else
        begin
            add_event(EV_SCROLL, '0, '0, '0, '0, cur_back);
            cur_row = ROW_W'(rows - 1);
        end
    endtask

    function automatic logic [7:0] sat_digit(input logic [7:0] p, input logic [7:0] b);
        int v;
        v = int'(p) * 10 + int'(b) - int'(CH_ZERO);
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    // Work out the words one accepted byte causes and advance the console state
    task automatic console_step(input logic [7:0] b);
        int unsigned cols;
        logic wrap;
        logic is_letter;
        burst_n = 0;
        cols = (width_cells == 0) ? 1 : width_cells;
        is_letter = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        if (esc_phase == PH_ESC)
        begin
            seq_bad = (b != CH_LBRACK);
            on_p2 = 1'b0;
            p1 = '0;
            p1_seen = 1'b0;
            p2 = '0;
            esc_phase = PH_PARAM;
        end
        else if (esc_phase != PH_TEXT)
        begin
            if (is_letter)
            begin
                if (!seq_bad && b == CH_SGR)
                begin
                    if (!p1_seen || p1 == 0)
                    begin
                        cur_fore = reset_fore;
                        cur_back = reset_back;
                    end
                    else if (p1 == 1)
                    begin
                        if (p2 >= 30 && p2 <= 37)
                            cur_fore = PAL_BRIGHT[3'(p2 - 8'd30)];
                        else if (p2 >= 40 && p2 <= 47)
                            cur_back = PAL_BRIGHT[3'(p2 - 8'd40)];
                    end
                    else if (p1 >= 30 && p1 <= 37)
                        cur_fore = PAL_NORMAL[3'(p1 - 8'd30)];
                    else if (p1 >= 40 && p1 <= 47)
                        cur_back = PAL_NORMAL[3'(p1 - 8'd40)];
                end
                esc_phase = PH_TEXT;
            end
            else if (b >= CH_ZERO && b <= CH_NINE)
            begin
                if (on_p2)
                    p2 = sat_digit(p2, b);
                else
                begin
                    p1 = sat_digit(p1, b);
                    p1_seen = 1'b1;
                end
            end
            else if (b == CH_SEMI && !on_p2)
                on_p2 = 1'b1;
            else
                seq_bad = 1'b1;
        end
        else if (b == CH_ESC)
            esc_phase = PH_ESC;
        else if (b == CH_NL)
            line_feed();
        else if (b == CH_BS)
        begin
            if (cur_col > 0)
                cur_col = cur_col - 1'b1;
        end
        else if (b == CH_TAB)
        begin
            wrap = 1'b0;
            do
            begin
                add_event(EV_DRAW, cur_col, cur_row, CH_SPACE, cur_fore, cur_back);
                cur_col = cur_col + 1'b1;
                if (cur_col >= cols || cur_col == 0)
                    wrap = 1'b1;
            end
            while (!wrap && cur_col[1:0] != 2'b00);
            if (wrap)
                line_feed();
        end
        else
        begin
            add_event(EV_DRAW, cur_col, cur_row, b, cur_fore, cur_back);
            cur_col = cur_col + 1'b1;
            if (cur_col >= cols || cur_col == 0)
                line_feed();
        end
        if (burst_n > 0)
            burst[burst_n - 1].last = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input result_t hand = '0);
        int gap;
        int k;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_bytes++;
        console_step(b);
        // a typed row stands in for the model's single word
        for (k = 0; k < burst_n; k++)
            due_events.push_back((typed && k == 0) ? hand : burst[k]);
    endtask

    task automatic send_number(input int v);
        if (v >= 100)
            send_byte(8'(CH_ZERO + (v / 100)));
        if (v >= 10)
            send_byte(8'(CH_ZERO + (v / 10) % 10));
        send_byte(8'(CH_ZERO + v % 10));
    endtask

    task automatic send_letter();
        int pick;
        pick = $urandom_range(0, 51);
        send_byte((pick < 26) ? 8'("A" + pick) : 8'("a" + pick - 26));
    endtask

    // Mostly text and well-formed colour sequences, some broken sequences and raw noise
    task automatic send_random_text(input int n);
        int stop;
        int r;
        int s;
        stop = sent_bytes + n;
        while (sent_bytes < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_byte(8'($urandom_range(32, 126)));
            else if (r < 55)
                send_byte(CH_NL);
            else if (r < 60)
                send_byte(CH_BS);
            else if (r < 68)
                send_byte(CH_TAB);
            else if (r < 88)
            begin
                send_byte(CH_ESC);
                send_byte(CH_LBRACK);
                s = $urandom_range(0, 5);
                case (s)
                    1: send_number($urandom_range(0, 2) == 0 ? 0 :
                                   ($urandom_range(0, 1) ? 30 : 40) + $urandom_range(0, 7));
                    2:
                    begin
                        send_byte(8'(CH_ZERO + 1));
                        send_byte(CH_SEMI);
                        send_number(($urandom_range(0, 1) ? 30 : 40) + $urandom_range(0, 7));
                    end
                    3:
                    begin
                        send_number($urandom_range(0, 999));
                        if ($urandom_range(0, 1))
                        begin
                            send_byte(CH_SEMI);
                            send_number($urandom_range(0, 999));
                        end
                    end
                    4: send_number(0);
                    5:
                    begin
                        send_number($urandom_range(1, 50));
                        send_byte(CH_SEMI);
                        send_number($urandom_range(0, 99));
                    end
                    default: ;
                endcase
                if ($urandom_range(0, 99) < 85)
                    send_byte(CH_SGR);
                else
                    send_letter();
            end
            else if (r < 95)
            begin
                send_byte(CH_ESC);
                s = $urandom_range(0, 2);
                if (s == 0)
                    send_byte(8'($urandom_range(0, 255)));
                else
                    send_byte(CH_LBRACK);
                send_number($urandom_range(0, 99));
                if (s == 1)
                begin
                    send_byte(CH_SEMI);
                    send_number($urandom_range(0, 99));
                    send_byte(CH_SEMI);
                    send_number($urandom_range(0, 99));
                end
                else if (s == 2)
                    send_byte(8'($urandom_range(0, 255)));
                send_byte(CH_SGR);
            end
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Hold input and wait until every owed word has arrived
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_console(input logic [COL_W-1:0] cols, input logic [ROW_W-1:0] rows,
                               input logic [RGB_W-1:0] fore, input logic [RGB_W-1:0] back);
        cfg_we <= 1'b1;
        cfg_index <= REG_COLUMN_COUNT;
        cfg_data <= RGB_W'(cols);
        @(posedge clk);
        cfg_index <= REG_ROW_COUNT;
        cfg_data <= RGB_W'(rows);
        @(posedge clk);
        cfg_index <= REG_DEFAULT_FORE;
        cfg_data <= fore;
        @(posedge clk);
        cfg_index <= REG_DEFAULT_BACK;
        cfg_data <= back;
        @(posedge clk);
        cfg_we <= 1'b0;
        width_cells = cols;
        height_rows = rows;
        reset_fore = fore;
        reset_back = back;
    endtask

    // Receiver: stall a random number of cycles before each word
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata[8:0], m_axis_tdata[16:9], m_axis_tdata[24:17],
                   m_axis_tdata[48:25], m_axis_tdata[72:49], m_axis_tlast};
            if (due_events.size() == 0)
                note_fault($sformatf("unexpected word: kind %0d col %0d row %0d glyph %h",
                                     got.kind, got.column, got.row, got.glyph));
            else
            begin
                want = due_events.pop_front();
                if (got.kind !== want.kind || got.column !== want.column ||
                    got.row !== want.row || got.glyph !== want.glyph ||
                    got.fore !== want.fore || got.back !== want.back ||
                    got.last !== want.last)
                    note_fault($sformatf({"mismatch: expected kind %0d col %0d row %0d glyph %h",
                                          " fg %h bg %h last %0d, got kind %0d col %0d row %0d",
                                          " glyph %h fg %h bg %h last %0d"},
                                         want.kind, want.column, want.row, want.glyph,
                                         want.fore, want.back, want.last,
                                         got.kind, got.column, got.row, got.glyph,
                                         got.fore, got.back, got.last));
            end
        end
    end

    initial
    begin
        #(8 * 500000);
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        steady = 1'b0;
        fault_count = 0;
        sent_bytes = 0;
        width_cells = COLUMN_COUNT_RST;
        height_rows = ROW_COUNT_RST;
        reset_fore = DEFAULT_FORE_RST;
        reset_back = DEFAULT_BACK_RST;
        cur_col = '0;
        cur_row = '0;
        esc_phase = PH_TEXT;
        seq_bad = 1'b0;
        on_p2 = 1'b0;
        p1_seen = 1'b0;
        p1 = '0;
        p2 = '0;
        cur_fore = DEFAULT_FORE_RST;
        cur_back = DEFAULT_BACK_RST;

        // Byte extremes, backspace back to column 0, tab, newline, colour sequences
        opening_rows = '{
            '{8'h41, 1'b1, {EV_DRAW, 9'd0, 8'd0, 8'h41, DEFAULT_FORE_RST, 24'h000000, 1'b1}},
            '{8'h00, 1'b1, {EV_DRAW, 9'd1, 8'd0, 8'h00, DEFAULT_FORE_RST, 24'h000000, 1'b1}},
            '{8'hff, 1'b1, {EV_DRAW, 9'd2, 8'd0, 8'hff, DEFAULT_FORE_RST, 24'h000000, 1'b1}},
            '{CH_BS, 1'b0, '0},
            '{CH_BS, 1'b0, '0},
            '{CH_BS, 1'b0, '0},
            '{CH_TAB, 1'b0, '0},
            '{CH_NL, 1'b0, '0},
            '{CH_ESC, 1'b0, '0},
            '{CH_LBRACK, 1'b0, '0},
            '{8'h33, 1'b0, '0},
            '{8'h31, 1'b0, '0},
            '{CH_SGR, 1'b0, '0},
            '{8'h78, 1'b1, {EV_DRAW, 9'd0, 8'd1, 8'h78, 24'haa0000, 24'h000000, 1'b1}},
            '{CH_ESC, 1'b0, '0},
            '{CH_LBRACK, 1'b0, '0},
            '{8'h31, 1'b0, '0},
            '{CH_SEMI, 1'b0, '0},
            '{8'h34, 1'b0, '0},
            '{8'h37, 1'b0, '0},
            '{CH_SGR, 1'b0, '0},
            '{CH_ESC, 1'b0, '0},
            '{CH_LBRACK, 1'b0, '0},
            '{CH_SGR, 1'b0, '0},
            '{8'h7e, 1'b1, {EV_DRAW, 9'd1, 8'd1, 8'h7e, DEFAULT_FORE_RST, 24'h000000, 1'b1}}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 25; i++)
            send_byte(opening_rows[i].code, opening_rows[i].typed, opening_rows[i].word);
        send_random_text(50);

        // Single cell screen: every draw wraps and scrolls
        settle();
        set_console(9'd1, 8'd1, 24'h000000, 24'hffffff);
        send_random_text(25);

        settle();
        set_console(9'd511, 8'd255, 24'hffffff, 24'h000000);
        send_random_text(30);

        // Zero counts act as one; cursor is left beyond the new geometry
        settle();
        set_console(9'd0, 8'd0, RGB_W'($urandom_range(0, 24'hffffff)),
                    RGB_W'($urandom_range(0, 24'hffffff)));
        send_random_text(15);

        settle();
        set_console(COL_W'($urandom_range(4, 20)), ROW_W'($urandom_range(2, 6)),
                    RGB_W'($urandom_range(0, 24'hffffff)),
                    RGB_W'($urandom_range(0, 24'hffffff)));
        steady = 1'b1;
        send_random_text(35);
        steady = 1'b0;
        send_random_text(40);

        settle();
        if (due_events.size() != 0)
            note_fault($sformatf("%0d words never arrived", due_events.size()));
        if (fault_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
